[hw/rtl/ugbp_pkg.sv]
// Shared types and constants of the uniform grid broad phase block.
// Depends on nothing; every other file uses it.
package ugbp_pkg;

  localparam int MAX_COLS_DEF    = 32;
  localparam int MAX_ROWS_DEF    = 32;
  localparam int CELL_CAP_DEF    = 8;
  localparam int MAX_RESULTS_DEF = 64;
  localparam int ID_BITS_DEF     = 16;

  localparam int CMD_W      = 2;
  localparam int ID_W       = 16;
  localparam int POS_W      = 16;
  localparam int SIZE_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CS_W       = 11;
  localparam int GRID_W     = 6;

  localparam logic [CMD_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] OP_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd2;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic div_start;
    logic div_run;
    logic bound;
    logic cell_init;
    logic cell_next;
    logic ins_write;
    logic slot_init;
    logic slot_next;
    logic check;
    logic pass_step;
    logic out_init;
    logic out_next;
    logic ld_ack;
    logic ld_data;
  } ugbp_cmd_t;

  typedef struct packed {
    logic             clr_done;
    logic             div_done;
    logic             nonempty;
    logic             last_cell;
    logic             cnt_zero;
    logic             last_slot;
    logic             found;
    logic             k_full;
    logic             k_zero;
    logic             last_out;
    logic [CMD_W-1:0] op;
  } ugbp_stat_t;

endpackage

[hw/rtl/ugbp_if.sv]
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on ugbp_pkg for field widths.
interface ugbp_req_if;
  logic                               valid;
  logic                               ready;
  logic [ugbp_pkg::CMD_W-1:0]         cmd;
  logic [ugbp_pkg::ID_W-1:0]          entity_id;
  logic signed [ugbp_pkg::POS_W-1:0]  pos_x;
  logic signed [ugbp_pkg::POS_W-1:0]  pos_y;
  logic [ugbp_pkg::SIZE_W-1:0]        size_w;
  logic [ugbp_pkg::SIZE_W-1:0]        size_h;
  modport source (output valid, cmd, entity_id, pos_x, pos_y, size_w, size_h, input ready);
  modport sink (input valid, cmd, entity_id, pos_x, pos_y, size_w, size_h, output ready);
endinterface

interface ugbp_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [ugbp_pkg::ID_W-1:0] out_id;
  logic                      empty_res;
  logic                      overflow;
  logic                      truncated;
  logic                      last;
  modport source (output valid, out_id, empty_res, overflow, truncated, last, input ready);
  modport sink (input valid, out_id, empty_res, overflow, truncated, last, output ready);
endinterface

interface ugbp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ugbp_pkg::CFG_IDX_W-1:0]  index;
  logic [ugbp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/uniform_grid_broad_phase_top.sv]
// Top level of the uniform grid broad phase block.
// Depends on ugbp_pkg, ugbp_if, ugbp_ctrl and ugbp_dp.
//
//  channel  dir  fields
//  req      in   cmd, entity_id, pos_x, pos_y, size_w, size_h
//  rsp      out  out_id, empty_res, overflow, truncated, last
//  cfg      in   index, data (always ready)
//
// One item at a time: a request is taken only when the previous one has
// transferred its last result. Reset and a clear command sweep the fill
// counts. Insert and query first run four floor divisions on the serial
// divider, then walk the covered cells; a query makes one pass per result id
// over all covered entries, then transfers the results. A stalled result
// holds the block.
module uniform_grid_broad_phase_top #(
  parameter int MAX_COLS    = ugbp_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = ugbp_pkg::MAX_ROWS_DEF,
  parameter int CELL_CAP    = ugbp_pkg::CELL_CAP_DEF,
  parameter int MAX_RESULTS = ugbp_pkg::MAX_RESULTS_DEF,
  parameter int ID_BITS     = ugbp_pkg::ID_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  ugbp_req_if.sink   req,
  ugbp_rsp_if.source rsp,
  ugbp_cfg_if.sink   cfg
);
  import ugbp_pkg::*;

  ugbp_cmd_t  cmd;
  ugbp_stat_t stat;

  assign cfg.ready = 1'b1;

  ugbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ugbp_dp #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .CELL_CAP    (CELL_CAP),
    .MAX_RESULTS (MAX_RESULTS),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_idx   (cfg.index),
    .cfg_data  (cfg.data),
    .in_cmd    (req.cmd),
    .in_id     (req.entity_id),
    .in_x      (req.pos_x),
    .in_y      (req.pos_y),
    .in_w      (req.size_w),
    .in_h      (req.size_h),
    .cmd       (cmd),
    .stat      (stat),
    .out_id    (rsp.out_id),
    .empty_res (rsp.empty_res),
    .overflow  (rsp.overflow),
    .truncated (rsp.truncated),
    .last      (rsp.last)
  );

endmodule

[hw/rtl/ugbp_dp.sv]
// Datapath: config registers, item latch, serial divider, cell/entry/gather
// memories, scan counters and output register. Depends on ugbp_pkg.
module ugbp_dp #(
  parameter int MAX_COLS    = ugbp_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = ugbp_pkg::MAX_ROWS_DEF,
  parameter int CELL_CAP    = ugbp_pkg::CELL_CAP_DEF,
  parameter int MAX_RESULTS = ugbp_pkg::MAX_RESULTS_DEF,
  parameter int ID_BITS     = ugbp_pkg::ID_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ugbp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [ugbp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [ugbp_pkg::CMD_W-1:0]         in_cmd,
  input  logic [ugbp_pkg::ID_W-1:0]          in_id,
  input  logic signed [ugbp_pkg::POS_W-1:0]  in_x,
  input  logic signed [ugbp_pkg::POS_W-1:0]  in_y,
  input  logic [ugbp_pkg::SIZE_W-1:0]        in_w,
  input  logic [ugbp_pkg::SIZE_W-1:0]        in_h,
  input  ugbp_pkg::ugbp_cmd_t                cmd,
  output ugbp_pkg::ugbp_stat_t               stat,
  output logic [ugbp_pkg::ID_W-1:0]          out_id,
  output logic                               empty_res,
  output logic                               overflow,
  output logic                               truncated,
  output logic                               last
);
  import ugbp_pkg::*;

  localparam int NCELLS = MAX_COLS * MAX_ROWS;
  localparam int NENT   = NCELLS * CELL_CAP;
  localparam int CAW    = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int EAW    = (NENT > 1) ? $clog2(NENT) : 1;
  localparam int CNTW   = $clog2(CELL_CAP + 1);
  localparam int CIW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RIW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int KW     = $clog2(MAX_RESULTS + 1);
  localparam int GIW    = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam logic [4:0] DIV_LAST = 5'd18;

  logic [CS_W-1:0]   cs_cfg;
  logic [GRID_W-1:0] grid_cols;
  logic [GRID_W-1:0] grid_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      cs_cfg    <= CS_W'(32);
      grid_cols <= GRID_W'(32);
      grid_rows <= GRID_W'(32);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_CELL_SIZE: cs_cfg <= cfg_data;
        CFG_GRID_COLS: grid_cols <= cfg_data[GRID_W-1:0];
        CFG_GRID_ROWS: grid_rows <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CMD_W-1:0]        op;
  logic [ID_BITS-1:0]      id_r;
  logic signed [POS_W-1:0] px, py;
  logic [SIZE_W-1:0]       sw, sh;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_cmd;
      id_r <= ID_BITS'(in_id);
      px   <= in_x;
      py   <= in_y;
      sw   <= in_w;
      sh   <= in_h;
    end
  end

  logic [CS_W-1:0] cs;
  logic [9:0]      nc, nr;
  assign cs = (cs_cfg == '0) ? CS_W'(1) : cs_cfg;
  assign nc = (grid_cols == '0) ? 10'd1 :
              (({4'b0, grid_cols} > 10'(MAX_COLS)) ? 10'(MAX_COLS) : {4'b0, grid_cols});
  assign nr = (grid_rows == '0) ? 10'd1 :
              (({4'b0, grid_rows} > 10'(MAX_ROWS)) ? 10'(MAX_ROWS) : {4'b0, grid_rows});

  // serial restoring divider, one quotient bit per cycle
  logic [1:0]         dsel;
  logic [4:0]         dcnt;
  logic [16:0]        num;
  logic [10:0]        rem;
  logic               dneg;
  logic signed [16:0] dvd;
  logic [16:0]        mag;
  logic [11:0]        trial;
  logic               ge;
  logic signed [17:0] qpos, qv;
  logic signed [17:0] q [4];

  always_comb begin
    case (dsel)
      2'd0:    dvd = {px[POS_W-1], px};
      2'd1:    dvd = {px[POS_W-1], px} + $signed({2'b0, sw});
      2'd2:    dvd = {py[POS_W-1], py};
      default: dvd = {py[POS_W-1], py} + $signed({2'b0, sh});
    endcase
    mag   = dvd[16] ? 17'(-dvd) : 17'(dvd);
    trial = {rem, num[16]};
    ge    = trial >= {1'b0, cs};
    qpos  = $signed({1'b0, num});
    qv    = dneg ? (-qpos - $signed({17'b0, rem != '0})) : qpos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dsel <= '0;
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dsel <= '0;
      dcnt <= '0;
    end else if (cmd.div_run) begin
      if (dcnt == '0) begin
        num  <= mag;
        rem  <= '0;
        dneg <= dvd[16];
        dcnt <= 5'd1;
      end else if (dcnt == DIV_LAST) begin
        q[dsel] <= qv;
        dsel    <= dsel + 2'd1;
        dcnt    <= '0;
      end else begin
        rem  <= ge ? 11'(trial - {1'b0, cs}) : trial[10:0];
        num  <= {num[15:0], ge};
        dcnt <= dcnt + 5'd1;
      end
    end
  end

  logic signed [17:0] c0, c1, r0, r1, ncm1, nrm1;
  assign ncm1 = $signed({8'b0, nc}) - 18'sd1;
  assign nrm1 = $signed({8'b0, nr}) - 18'sd1;

  always_ff @(posedge clk) begin
    if (cmd.bound) begin
      c0 <= (q[0] < 0) ? 18'sd0 : q[0];
      c1 <= (q[1] > ncm1) ? ncm1 : q[1];
      r0 <= (q[2] < 0) ? 18'sd0 : q[2];
      r1 <= (q[3] > nrm1) ? nrm1 : q[3];
    end
  end

  // cell scan counters
  logic [CIW-1:0]  col;
  logic [RIW-1:0]  row;
  logic [CNTW-1:0] slot;
  logic [CAW-1:0]  cell_addr;
  logic            last_col;

  assign last_col  = col == c1[CIW-1:0];
  assign cell_addr = CAW'(32'(row) * 32'(nc) + 32'(col));

  always_ff @(posedge clk) begin
    if (cmd.cell_init) begin
      col <= c0[CIW-1:0];
      row <= r0[RIW-1:0];
    end else if (cmd.cell_next) begin
      if (last_col) begin
        col <= c0[CIW-1:0];
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
    if (cmd.slot_init) begin
      slot <= '0;
    end else if (cmd.slot_next) begin
      slot <= slot + 1'b1;
    end
  end

  // fill counts, swept to zero after reset and on clear
  logic [CNTW-1:0] cnt_mem [NCELLS];
  logic [CNTW-1:0] cnt_q;
  logic [CAW-1:0]  clr_addr;
  logic            clr_done, cnt_full, do_ins;

  assign clr_done = clr_addr == CAW'(NCELLS - 1);
  assign cnt_full = cnt_q >= CNTW'(CELL_CAP);
  assign do_ins   = cmd.ins_write && !cnt_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_done ? '0 : clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step || do_ins) begin
      cnt_mem[cmd.clr_step ? clr_addr : cell_addr] <= cmd.clr_step ? '0 : cnt_q + 1'b1;
    end
    cnt_q <= cnt_mem[cell_addr];
  end

  logic [ID_BITS-1:0] ent_mem [NENT];
  logic [ID_BITS-1:0] ent_q;
  logic [EAW-1:0]     ent_waddr, ent_raddr;

  assign ent_waddr = EAW'(32'(cell_addr) * CELL_CAP + 32'(cnt_q));
  assign ent_raddr = EAW'(32'(cell_addr) * CELL_CAP + 32'(slot));

  always_ff @(posedge clk) begin
    if (do_ins) begin
      ent_mem[ent_waddr] <= id_r;
    end
    ent_q <= ent_mem[ent_raddr];
  end

  // one pass per result: find the smallest id above the previous one
  logic [ID_BITS-1:0] best, prev;
  logic               found, ovf, trunc;
  logic [KW-1:0]      k, e;
  logic               k_full, take;

  assign k_full = k == KW'(MAX_RESULTS);
  assign take   = ((k == '0) || (ent_q > prev)) && (!found || (ent_q < best));

  logic [ID_BITS-1:0] gbuf [MAX_RESULTS];
  logic [ID_BITS-1:0] gq;

  always_ff @(posedge clk) begin
    if (cmd.pass_step && found && !k_full) begin
      gbuf[k[GIW-1:0]] <= best;
    end
    gq <= gbuf[e[GIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      ovf   <= 1'b0;
      trunc <= 1'b0;
      k     <= '0;
      e     <= '0;
    end else begin
      if (cmd.load) begin
        ovf <= 1'b0;
      end else if (cmd.ins_write && cnt_full) begin
        ovf <= 1'b1;
      end
      if (cmd.bound) begin
        k     <= '0;
        trunc <= 1'b0;
      end else if (cmd.pass_step && found) begin
        if (k_full) begin
          trunc <= 1'b1;
        end else begin
          k    <= k + 1'b1;
          prev <= best;
        end
      end
      if (cmd.bound || cmd.cell_init) begin
        found <= 1'b0;
      end else if (cmd.check && take) begin
        found <= 1'b1;
        best  <= ent_q;
      end
      if (cmd.out_init) begin
        e <= '0;
      end else if (cmd.out_next) begin
        e <= e + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= 1'b0;
    end else if (cmd.ld_ack) begin
      out_id    <= '0;
      empty_res <= 1'b1;
      overflow  <= ovf;
      truncated <= 1'b0;
      last      <= 1'b1;
    end else if (cmd.ld_data) begin
      out_id    <= ID_W'(gq);
      empty_res <= 1'b0;
      overflow  <= 1'b0;
      truncated <= trunc;
      last      <= KW'(e + 1'b1) == k;
    end
  end

  assign stat.clr_done  = clr_done;
  assign stat.div_done  = (dcnt == DIV_LAST) && (dsel == 2'd3);
  assign stat.nonempty  = (c0 <= c1) && (r0 <= r1);
  assign stat.last_cell = last_col && (row == r1[RIW-1:0]);
  assign stat.cnt_zero  = cnt_q == '0;
  assign stat.last_slot = CNTW'(slot + 1'b1) == cnt_q;
  assign stat.found     = found;
  assign stat.k_full    = k_full;
  assign stat.k_zero    = k == '0;
  assign stat.last_out  = last;
  assign stat.op        = op;

endmodule

[hw/rtl/ugbp_ctrl.sv]
// Controller state machine: sequences clear sweep, division, cell scan,
// query passes and result transfer. Depends on ugbp_pkg.
module ugbp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  ugbp_pkg::ugbp_stat_t stat,
  output ugbp_pkg::ugbp_cmd_t  cmd
);
  import ugbp_pkg::*;

  localparam logic [4:0] ST_RCLR  = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_DISP  = 5'd2;
  localparam logic [4:0] ST_CCLR  = 5'd3;
  localparam logic [4:0] ST_DIV   = 5'd4;
  localparam logic [4:0] ST_BND   = 5'd5;
  localparam logic [4:0] ST_BCHK  = 5'd6;
  localparam logic [4:0] ST_CELL  = 5'd7;
  localparam logic [4:0] ST_CWAIT = 5'd8;
  localparam logic [4:0] ST_ERD   = 5'd9;
  localparam logic [4:0] ST_ECHK  = 5'd10;
  localparam logic [4:0] ST_PASS  = 5'd11;
  localparam logic [4:0] ST_EMIT  = 5'd12;
  localparam logic [4:0] ST_ORD   = 5'd13;
  localparam logic [4:0] ST_ACK   = 5'd14;
  localparam logic [4:0] ST_OWAIT = 5'd15;
  localparam logic [4:0] ST_ORW   = 5'd16;

  logic [4:0] state, state_next;
  logic       is_ins;

  assign is_ins    = stat.op == OP_INSERT;
  assign req_ready = state == ST_IDLE;
  assign rsp_valid = state == ST_OWAIT;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_RCLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        if (stat.op == OP_CLEAR) begin
          state_next = ST_CCLR;
        end else if (stat.op == OP_INSERT || stat.op == OP_QUERY) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_ACK;
        end
      end
      ST_CCLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = ST_ACK;
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (stat.div_done) state_next = ST_BND;
      end
      ST_BND: begin
        cmd.bound  = 1'b1;
        state_next = ST_BCHK;
      end
      ST_BCHK: begin
        if (stat.nonempty) begin
          cmd.cell_init = 1'b1;
          state_next    = ST_CELL;
        end else begin
          state_next = is_ins ? ST_ACK : ST_EMIT;
        end
      end
      ST_CELL: state_next = ST_CWAIT;
      ST_CWAIT: begin
        if (is_ins) begin
          cmd.ins_write = 1'b1;
          if (stat.last_cell) begin
            state_next = ST_ACK;
          end else begin
            cmd.cell_next = 1'b1;
            state_next    = ST_CELL;
          end
        end else if (stat.cnt_zero) begin
          if (stat.last_cell) begin
            state_next = ST_PASS;
          end else begin
            cmd.cell_next = 1'b1;
            state_next    = ST_CELL;
          end
        end else begin
          cmd.slot_init = 1'b1;
          state_next    = ST_ERD;
        end
      end
      ST_ERD: state_next = ST_ECHK;
      ST_ECHK: begin
        cmd.check = 1'b1;
        if (!stat.last_slot) begin
          cmd.slot_next = 1'b1;
          state_next    = ST_ERD;
        end else if (stat.last_cell) begin
          state_next = ST_PASS;
        end else begin
          cmd.cell_next = 1'b1;
          state_next    = ST_CELL;
        end
      end
      ST_PASS: begin
        cmd.pass_step = 1'b1;
        if (stat.found && !stat.k_full) begin
          cmd.cell_init = 1'b1;
          state_next    = ST_CELL;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.k_zero) begin
          cmd.ld_ack = 1'b1;
          state_next = ST_OWAIT;
        end else begin
          cmd.out_init = 1'b1;
          state_next   = ST_ORW;
        end
      end
      ST_ORW: state_next = ST_ORD;
      ST_ORD: begin
        cmd.ld_data = 1'b1;
        state_next  = ST_OWAIT;
      end
      ST_ACK: begin
        cmd.ld_ack = 1'b1;
        state_next = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (rsp_ready) begin
          if (stat.last_out) begin
            state_next = ST_IDLE;
          end else begin
            cmd.out_next = 1'b1;
            state_next   = ST_ORW;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RCLR;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_DISP))
    else $error("accepted item not dispatched");
  a_ins_only_insert: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |-> (stat.op == OP_INSERT))
    else $error("cell write outside insert");
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && stat.last_out) |=> (state == ST_IDLE))
    else $error("final result did not end the item");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && !stat.last_out) |=> !req_ready)
    else $error("input taken while results remain");
`endif

endmodule

[verif/tb_top.sv]
// Self-checking bench for the uniform grid broad phase block.
// Depends on ugbp_pkg, the channel interfaces in ugbp_if and the block's top level.
// Predicts clear, insert and query results in step with the bus and checks each transfer.
`timescale 1ns / 1ps

module tb_top;
  import ugbp_pkg::*;

  localparam logic [CMD_W-1:0] OP_UNUSED = 2'd3;
  localparam int NCELL      = MAX_COLS_DEF * MAX_ROWS_DEF;
  localparam int IDLE_LIMIT = 3000000;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic [ID_W-1:0]          id;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [SIZE_W-1:0]        w;
    logic [SIZE_W-1:0]        h;
  } grid_req_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic            empty;
    logic            ovf;
    logic            trunc;
    logic            last;
  } grid_hit_t;

  logic clk;
  logic rst;

  ugbp_req_if req_ch();
  ugbp_rsp_if rsp_ch();
  ugbp_cfg_if cfg_ch();

  uniform_grid_broad_phase_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  logic [CS_W-1:0]   cur_cs;
  logic [GRID_W-1:0] cur_cols;
  logic [GRID_W-1:0] cur_rows;
  logic [ID_W-1:0]   cell_ids [0:NCELL-1][0:CELL_CAP_DEF-1];
  int                cell_fill [0:NCELL-1];

  grid_req_t pending_reqs[$];
  grid_hit_t expected_hits[$];

  int  errors, n_in, n_out, n_trunc, n_ovf, idle_cycles;
  bit  req_took, rsp_took;
  bit  hold_off;
  bit  tx_calm, rx_calm;
  int  tx_gap, rx_wait;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int floor_div(int a, int d);
    int q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic bit cover_range(grid_req_t r, output int c0, output int c1,
                                     output int r0, output int r1, output int nc);
    int cs, nr;
    cs = (cur_cs == 0) ? 1 : int'(cur_cs);
    nc = (cur_cols == 0) ? 1 : (cur_cols > MAX_COLS_DEF ? MAX_COLS_DEF : int'(cur_cols));
    nr = (cur_rows == 0) ? 1 : (cur_rows > MAX_ROWS_DEF ? MAX_ROWS_DEF : int'(cur_rows));
    c0 = floor_div(int'(r.x), cs);
    c1 = floor_div(int'(r.x) + int'(r.w), cs);
    r0 = floor_div(int'(r.y), cs);
    r1 = floor_div(int'(r.y) + int'(r.h), cs);
    if (c0 < 0) c0 = 0;
    if (c1 > nc - 1) c1 = nc - 1;
    if (r0 < 0) r0 = 0;
    if (r1 > nr - 1) r1 = nr - 1;
    return c0 <= c1 && r0 <= r1;
  endfunction

  task automatic add_hit(grid_hit_t e);
    expected_hits.insert(expected_hits.size(), e);
  endtask

  task automatic queue_req(grid_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic push_ack(bit ovf);
    grid_hit_t e;
    e = '{id: '0, empty: 1'b1, ovf: ovf, trunc: 1'b0, last: 1'b1};
    add_hit(e);
  endtask

  task automatic grid_apply(grid_req_t r);
    int c0, c1, r0, r1, nc, cidx;
    bit any, ovf, trunc;
    bit seen [int];
    int found[$];
    grid_hit_t e;
    any = cover_range(r, c0, c1, r0, r1, nc);
    case (r.cmd)
      OP_CLEAR: begin
        foreach (cell_fill[i]) cell_fill[i] = 0;
        push_ack(1'b0);
      end
      OP_INSERT: begin
        ovf = 1'b0;
        if (any) begin
          for (int rr = r0; rr <= r1; rr++)
            for (int cc = c0; cc <= c1; cc++) begin
              cidx = rr * nc + cc;
              if (cell_fill[cidx] < CELL_CAP_DEF) begin
                cell_ids[cidx][cell_fill[cidx]] = r.id;
                cell_fill[cidx]++;
              end else begin
                ovf = 1'b1;
              end
            end
        end
        if (ovf) n_ovf++;
        push_ack(ovf);
      end
      OP_QUERY: begin
        if (any) begin
          for (int rr = r0; rr <= r1; rr++)
            for (int cc = c0; cc <= c1; cc++) begin
              cidx = rr * nc + cc;
              for (int k = 0; k < cell_fill[cidx]; k++)
                if (!seen.exists(int'(cell_ids[cidx][k]))) begin
                  seen[int'(cell_ids[cidx][k])] = 1'b1;
                  found.insert(found.size(), int'(cell_ids[cidx][k]));
                end
            end
        end
        found.sort();
        trunc = found.size() > MAX_RESULTS_DEF;
        while (found.size() > MAX_RESULTS_DEF) void'(found.pop_back());
        if (trunc) n_trunc++;
        if (found.size() == 0) begin
          push_ack(1'b0);
        end else begin
          foreach (found[i]) begin
            e = '{id: found[i][ID_W-1:0], empty: 1'b0, ovf: 1'b0, trunc: trunc,
                  last: (i == found.size() - 1)};
            add_hit(e);
          end
        end
      end
      default: push_ack(1'b0);
    endcase
  endtask

  task automatic report(string what, int got, int want);
    $display("[%0t] result %0d: %s got %0h want %0h", $time, n_out, what, got, want);
    errors++;
  endtask

  // monitor: sample at the rising edge
  always @(posedge clk) begin
    grid_req_t r;
    grid_hit_t e;
    req_took = !rst && req_ch.valid && req_ch.ready;
    rsp_took = !rst && rsp_ch.valid && rsp_ch.ready;
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_CELL_SIZE: cur_cs = cfg_ch.data[CS_W-1:0];
        CFG_GRID_COLS: cur_cols = cfg_ch.data[GRID_W-1:0];
        CFG_GRID_ROWS: cur_rows = cfg_ch.data[GRID_W-1:0];
        default: ;
      endcase
    end
    if (req_took) begin
      r = '{cmd: req_ch.cmd, id: req_ch.entity_id, x: req_ch.pos_x, y: req_ch.pos_y,
            w: req_ch.size_w, h: req_ch.size_h};
      grid_apply(r);
      n_in++;
    end
    if (rsp_took) begin
      n_out++;
      if (expected_hits.size() == 0) begin
        report("unexpected transfer, out_id", rsp_ch.out_id, 0);
      end else begin
        e = expected_hits.pop_front();
        if (rsp_ch.out_id !== e.id) report("out_id", rsp_ch.out_id, e.id);
        if (rsp_ch.empty_res !== e.empty) report("empty_res", rsp_ch.empty_res, e.empty);
        if (rsp_ch.overflow !== e.ovf) report("overflow", rsp_ch.overflow, e.ovf);
        if (rsp_ch.truncated !== e.trunc) report("truncated", rsp_ch.truncated, e.trunc);
        if (rsp_ch.last !== e.last) report("last", rsp_ch.last, e.last);
      end
    end
    if (req_took || rsp_took) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // request driver: change at the falling edge
  always @(negedge clk) begin
    grid_req_t r;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_took) begin
    end else if (tx_gap > 0) begin
      req_ch.valid <= 1'b0;
      tx_gap--;
    end else if (pending_reqs.size() > 0) begin
      r = pending_reqs.pop_front();
      req_ch.cmd       <= r.cmd;
      req_ch.entity_id <= r.id;
      req_ch.pos_x     <= r.x;
      req_ch.pos_y     <= r.y;
      req_ch.size_w    <= r.w;
      req_ch.size_h    <= r.h;
      req_ch.valid     <= 1'b1;
      tx_gap = draw_gap(tx_calm);
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_took) rx_wait = draw_gap(rx_calm);
      if (hold_off || rx_wait > 0) begin
        rsp_ch.ready <= 1'b0;
        if (!hold_off) rx_wait--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver stall while requests keep coming
  initial begin
    hold_off = 1'b0;
    wait (n_in >= 40);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  function automatic grid_req_t mk(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                   int x, int y, int w, int h);
    grid_req_t r;
    r = '{cmd: cmd, id: id, x: x[POS_W-1:0], y: y[POS_W-1:0],
          w: w[SIZE_W-1:0], h: h[SIZE_W-1:0]};
    return r;
  endfunction

  function automatic int rand_pos(int cs, int n);
    int v;
    if ($urandom_range(0, 9) == 0) return int'($signed(16'($urandom())));
    v = int'($urandom_range(0, (n + 3) * cs)) - 2 * cs;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic int rand_size(int cs);
    int v;
    if ($urandom_range(0, 11) == 0) return $urandom_range(0, 32767);
    v = $urandom_range(0, 2 * cs);
    return v > 32767 ? 32767 : v;
  endfunction

  task automatic add_random(int count);
    int cs, nc, nr, pick;
    logic [CMD_W-1:0] cmd;
    cs = (cur_cs == 0) ? 1 : int'(cur_cs);
    nc = (cur_cols == 0) ? 1 : int'(cur_cols);
    nr = (cur_rows == 0) ? 1 : int'(cur_rows);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      cmd = pick < 55 ? OP_INSERT : pick < 92 ? OP_QUERY : pick < 96 ? OP_CLEAR : OP_UNUSED;
      queue_req(mk(cmd, 16'($urandom()), rand_pos(cs, nc), rand_pos(cs, nr),
                   rand_size(cs), rand_size(cs)));
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || expected_hits.size() != 0 || req_ch.valid);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, int value);
    @(negedge clk);
    cfg_ch.index <= index;
    cfg_ch.data  <= value[CFG_DATA_W-1:0];
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_grid(int cs, int cols, int rows);
    wait_drained();
    write_reg(CFG_CELL_SIZE, cs);
    write_reg(CFG_GRID_COLS, cols);
    write_reg(CFG_GRID_ROWS, rows);
  endtask

  initial begin
    int base;
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = OP_CLEAR;
    req_ch.entity_id = '0;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.size_w = '0;
    req_ch.size_h = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_CELL_SIZE;
    cfg_ch.data = '0;
    cur_cs = 32;
    cur_cols = 32;
    cur_rows = 32;
    foreach (cell_fill[i]) cell_fill[i] = 0;
    errors = 0;
    n_in = 0;
    n_out = 0;
    n_trunc = 0;
    n_ovf = 0;
    idle_cycles = 0;
    tx_gap = 0;
    rx_wait = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    queue_req(mk(OP_CLEAR, 0, 0, 0, 0, 0));
    queue_req(mk(OP_QUERY, 0, 0, 0, 32767, 32767));
    queue_req(mk(OP_INSERT, 16'hFFFF, 0, 0, 0, 0));
    queue_req(mk(OP_INSERT, 0, -32768, -32768, 32767, 32767));
    queue_req(mk(OP_INSERT, 16'h1234, 32767, 32767, 32767, 32767));
    queue_req(mk(OP_INSERT, 5, -40, -40, 100, 100));
    for (int i = 0; i < 8; i++)
      queue_req(mk(OP_INSERT, 100 + i, 5, 5, 0, 0));
    queue_req(mk(OP_QUERY, 0, 0, 0, 0, 0));
    queue_req(mk(OP_QUERY, 16'hFFFF, 0, 0, 32767, 32767));
    queue_req(mk(OP_UNUSED, 16'hAAAA, -1, -1, 32767, 32767));
    queue_req(mk(OP_INSERT, 16'h8000, 1000, 1000, 31, 31));
    queue_req(mk(OP_QUERY, 0, 32, 0, 0, 0));
    queue_req(mk(OP_QUERY, 0, -32768, -32768, 32767, 32767));
    queue_req(mk(OP_CLEAR, 0, 0, 0, 0, 0));
    queue_req(mk(OP_QUERY, 0, 0, 0, 32767, 32767));

    set_grid(0, 0, 0);
    add_random(12);

    set_grid(2047, 63, 63);
    add_random(25);

    set_grid(8, 3, 3);
    queue_req(mk(OP_CLEAR, 0, 0, 0, 0, 0));
    base = $urandom();
    for (int i = 0; i < 70; i++)
      queue_req(mk(OP_INSERT, (base + i * 977) & 16'hFFFF,
                   (i % 3) * 8 + $urandom_range(0, 7),
                   ((i / 3) % 3) * 8 + $urandom_range(0, 7), 0, 0));
    queue_req(mk(OP_QUERY, 0, 0, 0, 23, 23));
    add_random(8);

    set_grid(1, 5, 7);
    add_random(20);

    set_grid(1024, 32, 1);
    add_random(20);

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Covered %0d requests and %0d result transfers over six grid settings",
             n_in, n_out);
    $display("Inserts that overflowed: %0d, truncated queries: %0d", n_ovf, n_trunc);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
